// File: rtl/core/ursc_pkg.sv
// package: shared types, register indexes and reset values for the ranging scanner
`timescale 1ns / 1ps

package ursc_pkg;

  localparam int SENSORS_DEF = 4;

  localparam int LEVEL_W = 4;
  localparam int READ_W = 2;
  localparam int TRIG_LEN_W = 10;
  localparam int TIMEOUT_W = 16;
  localparam int GAP_W = 20;
  localparam int SCALE_W = 16;
  localparam int COUNT_W = 20;
  localparam int ELAPSED_W = 16;
  localparam int DIST_W = 18;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 48;

  localparam logic [TRIG_LEN_W-1:0] TRIG_LEN_RST = 10'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd50000;
  localparam logic [GAP_W-1:0] GAP_RST = 20'd10000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1222;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TRIGGER_LENGTH = 2'd0,
    CFG_ECHO_TIMEOUT   = 2'd1,
    CFG_GAP_LENGTH     = 2'd2,
    CFG_SCALE          = 2'd3
  } cfg_addr_t;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_GAP     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_lines;
    logic               measure_done;
    logic [1:0]         done_sensor;
    logic [DIST_W-1:0]  done_distance;
    logic               done_timed_out;
  } tick_res_t;

endpackage

// File: rtl/core/ursc_scale.sv
// echo time to distance: q16 scale, round half up to 1/256 cm, saturate
`timescale 1ns / 1ps

module ursc_scale (
  input  logic [ursc_pkg::ELAPSED_W-1:0] elapsed,
  input  logic [ursc_pkg::SCALE_W-1:0]   scale_q16,
  output logic [ursc_pkg::DIST_W-1:0]    distance
);

  localparam int PROD_W = ursc_pkg::ELAPSED_W + ursc_pkg::SCALE_W;
  localparam int SHIFT_W = PROD_W + 1 - 8;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    rounded;
  logic [SHIFT_W-1:0] shifted;

  assign prod = elapsed * scale_q16;
  assign rounded = {1'b0, prod} + (PROD_W + 1)'(128);
  assign shifted = rounded[PROD_W:8];
  assign distance = (|shifted[SHIFT_W-1:ursc_pkg::DIST_W]) ? '1
                  : shifted[ursc_pkg::DIST_W-1:0];

endmodule

// File: rtl/core/ursc_store.sv
// per-sensor result store with write-through read
`timescale 1ns / 1ps

module ursc_store #(
  parameter int SENSORS = ursc_pkg::SENSORS_DEF,
  parameter int SW = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [SW-1:0]               wr_idx,
  input  logic [ursc_pkg::DIST_W-1:0] wr_dist,
  input  logic                        wr_flag,
  input  logic [ursc_pkg::READ_W-1:0] rd_sensor,
  output logic [ursc_pkg::DIST_W-1:0] rd_dist,
  output logic                        rd_flag
);

  logic [ursc_pkg::DIST_W-1:0] dist_r [SENSORS];
  logic                        flag_r [SENSORS];
  logic [SW-1:0]               rd_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        dist_r[i] <= '0;
        flag_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      dist_r[wr_idx] <= wr_dist;
      flag_r[wr_idx] <= wr_flag;
    end
  end

  assign rd_idx = SW'(rd_sensor);

  always_comb begin
    if (32'(rd_sensor) >= SENSORS) begin
      rd_dist = '0;
      rd_flag = 1'b1;
    end else if (wr_en && (wr_idx == rd_idx)) begin
      rd_dist = wr_dist;
      rd_flag = wr_flag;
    end else begin
      rd_dist = dist_r[rd_idx];
      rd_flag = flag_r[rd_idx];
    end
  end

endmodule

// File: rtl/core/ursc_seq.sv
// trigger / wait / gap sequencer with config registers and echo timing
`timescale 1ns / 1ps

module ursc_seq #(
  parameter int SENSORS = ursc_pkg::SENSORS_DEF,
  parameter int SW = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ursc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ursc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            tick,
  input  logic [ursc_pkg::LEVEL_W-1:0]    echo_levels,
  output ursc_pkg::tick_res_t             res,
  output logic                            wr_en,
  output logic [SW-1:0]                   wr_idx,
  output logic [ursc_pkg::DIST_W-1:0]     wr_dist,
  output logic                            wr_flag
);

  logic [ursc_pkg::TRIG_LEN_W-1:0] trig_len_r;
  logic [ursc_pkg::TIMEOUT_W-1:0]  timeout_r;
  logic [ursc_pkg::GAP_W-1:0]      gap_r;
  logic [ursc_pkg::SCALE_W-1:0]    scale_r;

  ursc_pkg::phase_t               phase_r, phase_nxt;
  logic [SW-1:0]                  active_r, active_nxt, active_inc;
  logic [ursc_pkg::COUNT_W-1:0]   count_r, count_nxt, count_inc;
  logic [ursc_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                           rise_r, rise_nxt;
  logic                           prev_r, prev_nxt;

  logic [ursc_pkg::LEVEL_W-1:0] sel;
  logic                         line;
  logic                         rise_edge;
  logic                         fall_done;
  logic                         finish;
  logic                         timed_out;
  logic [ursc_pkg::DIST_W-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_len_r <= ursc_pkg::TRIG_LEN_RST;
      timeout_r  <= ursc_pkg::TIMEOUT_RST;
      gap_r      <= ursc_pkg::GAP_RST;
      scale_r    <= ursc_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (ursc_pkg::cfg_addr_t'(cfg_addr))
        ursc_pkg::CFG_TRIGGER_LENGTH: trig_len_r <= cfg_wdata[ursc_pkg::TRIG_LEN_W-1:0];
        ursc_pkg::CFG_ECHO_TIMEOUT:   timeout_r <= cfg_wdata[ursc_pkg::TIMEOUT_W-1:0];
        ursc_pkg::CFG_GAP_LENGTH:     gap_r <= cfg_wdata[ursc_pkg::GAP_W-1:0];
        ursc_pkg::CFG_SCALE:          scale_r <= cfg_wdata[ursc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ursc_pkg::PH_TRIGGER;
      active_r  <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
      rise_r    <= 1'b0;
      prev_r    <= 1'b0;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      active_r  <= active_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      rise_r    <= rise_nxt;
      prev_r    <= prev_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < ursc_pkg::LEVEL_W; i++) begin
      sel[i] = (32'(active_r) == i);
    end
  end

  assign line = |(echo_levels & sel);
  assign count_inc = count_r + 1'b1;
  assign active_inc = (32'(active_r) >= SENSORS - 1) ? '0 : active_r + 1'b1;
  assign rise_edge = line && !prev_r;
  assign elapsed_inc = (rise_r && (elapsed_r != ursc_pkg::ELAPSED_MAX))
                     ? elapsed_r + 1'b1 : elapsed_r;
  assign fall_done = !rise_edge && !line && prev_r && rise_r;

  ursc_scale u_scale (
    .elapsed   (elapsed_inc),
    .scale_q16 (scale_r),
    .distance  (scaled)
  );

  always_comb begin
    phase_nxt   = phase_r;
    active_nxt  = active_r;
    count_nxt   = count_inc;
    elapsed_nxt = elapsed_r;
    rise_nxt    = rise_r;
    prev_nxt    = prev_r;
    finish      = 1'b0;
    timed_out   = 1'b0;
    res         = '0;
    case (phase_r)
      ursc_pkg::PH_TRIGGER: begin
        res.trigger_lines = sel;
        prev_nxt = line;
        if (count_inc >= ursc_pkg::COUNT_W'(trig_len_r)) begin
          phase_nxt   = ursc_pkg::PH_WAIT;
          count_nxt   = '0;
          elapsed_nxt = '0;
          rise_nxt    = 1'b0;
        end
      end
      ursc_pkg::PH_WAIT: begin
        prev_nxt = line;
        if (rise_edge) begin
          rise_nxt    = 1'b1;
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = elapsed_inc;
        end
        if (fall_done) begin
          finish = 1'b1;
        end else if (count_inc >= ursc_pkg::COUNT_W'(timeout_r)) begin
          finish    = 1'b1;
          timed_out = 1'b1;
        end
        if (finish) begin
          res.measure_done   = 1'b1;
          res.done_sensor    = 2'(active_r);
          res.done_distance  = timed_out ? '0 : scaled;
          res.done_timed_out = timed_out;
          rise_nxt    = 1'b0;
          elapsed_nxt = '0;
          count_nxt   = '0;
          if (gap_r == '0) begin
            phase_nxt  = ursc_pkg::PH_TRIGGER;
            active_nxt = active_inc;
          end else begin
            phase_nxt = ursc_pkg::PH_GAP;
          end
        end
      end
      ursc_pkg::PH_GAP: begin
        if (count_inc >= gap_r) begin
          phase_nxt  = ursc_pkg::PH_TRIGGER;
          active_nxt = active_inc;
          count_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = ursc_pkg::PH_TRIGGER;
        count_nxt = '0;
      end
    endcase
  end

  assign wr_en   = tick && finish;
  assign wr_idx  = active_r;
  assign wr_dist = res.done_distance;
  assign wr_flag = timed_out;

endmodule

// File: rtl/core/ultrasonic_ranging_scanner.sv
// top level: ultrasonic ranging scanner, one microsecond tick per input transfer
//
//   channel | ports                         | payload
//   in      | in_tvalid/in_tready/in_tdata  | echo_levels, read_sensor
//   out     | out_tvalid/out_tready/out_tdata | tick result and stored read-back
//   cfg     | cfg_we/cfg_addr/cfg_wdata     | trigger, timeout, gap, scale
//
// one tick in, one result out; a tick is taken every cycle while the result
// register is empty or being drained
// all work of a tick sits between the input port and the result register
// reset (synchronous) loads register defaults, clears the store and starts
// sensor 0 in its trigger phase
// a stalled out channel holds the result and blocks in; sequencer state waits
`timescale 1ns / 1ps

module ultrasonic_ranging_scanner #(
  parameter int SENSORS = ursc_pkg::SENSORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [3:0] echo_levels, [5:4] read_sensor, [7:6] zero
  input  logic [ursc_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] trigger_lines, [4] measure_done, [6:5] done_sensor,
  // [24:7] done_distance, [25] done_timed_out, [43:26] read_distance,
  // [44] read_timed_out, [47:45] zero
  output logic [ursc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [ursc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ursc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int PAD_W = ursc_pkg::OUT_DATA_W - 45;

  logic                        tick;
  ursc_pkg::tick_res_t         res;
  logic                        wr_en;
  logic [SW-1:0]               wr_idx;
  logic [ursc_pkg::DIST_W-1:0] wr_dist;
  logic                        wr_flag;
  logic [ursc_pkg::DIST_W-1:0] rd_dist;
  logic                        rd_flag;

  logic                           out_valid_r, out_valid_nxt;
  logic [ursc_pkg::OUT_DATA_W-1:0] out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign tick = in_tvalid && in_tready;

  ursc_seq #(
    .SENSORS (SENSORS),
    .SW      (SW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .tick        (tick),
    .echo_levels (in_tdata[3:0]),
    .res         (res),
    .wr_en       (wr_en),
    .wr_idx      (wr_idx),
    .wr_dist     (wr_dist),
    .wr_flag     (wr_flag)
  );

  ursc_store #(
    .SENSORS (SENSORS),
    .SW      (SW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_dist   (wr_dist),
    .wr_flag   (wr_flag),
    .rd_sensor (in_tdata[5:4]),
    .rd_dist   (rd_dist),
    .rd_flag   (rd_flag)
  );

  assign out_valid_nxt = tick || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_data_r <= {PAD_W'(0), rd_flag, rd_dist, res.done_timed_out, res.done_distance,
                     res.done_sensor, res.measure_done, res.trigger_lines};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// File: rtl/core/ursc_checker.sv
// port-level checker for the ranging scanner, bound to the top level
`timescale 1ns / 1ps

module ursc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ursc_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty result register");

  a_trigger_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[3:0]))
    else $error("more than one trigger line high");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> out_tdata[25:5] == '0)
    else $error("done fields set without a finished measurement");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |-> out_tdata[4] && (out_tdata[24:7] == '0)
      && (out_tdata[3:0] == '0))
    else $error("timeout result carries a distance or trigger");

endmodule

bind ultrasonic_ranging_scanner ursc_checker u_ursc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
